// ===== hdl/sawbc_pkg.sv =====
// Shared types and constants for the set-associative write-back cache.
// No dependencies; sawbc_front, sawbc_back, the top level and the checker import this package.
package sawbc_pkg;

    localparam int LINE_BYTES_LOG2 = 6;
    localparam int WORD_IDX_W      = 4;
    localparam int BLOCK_W         = 26;
    localparam logic [WORD_IDX_W-1:0] LAST_WORD = 4'd15;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_REFILL  = 2'd2,
        CMD_ILLEGAL = 2'd3
    } cmd_kind_t;

    typedef enum logic [2:0] {
        RK_READ   = 3'd0,
        RK_WRITE  = 3'd1,
        RK_WB     = 3'd2,
        RK_REFILL = 3'd3,
        RK_REJECT = 3'd4
    } res_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] mask;
    } cmd_t;

    typedef struct packed {
        res_kind_t              kind;
        logic [31:0]            data;
        logic [BLOCK_W-1:0]     block;
        logic [WORD_IDX_W-1:0]  idx;
        logic                   hit;
        logic                   last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_DATA,
        ST_WB_RD,
        ST_WB_OUT,
        ST_REQ,
        ST_FIN
    } state_t;

endpackage

// ===== hdl/sawbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sawbc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/sawbc_fifo.sv =====
// Two-entry queue of packed words, used between the stages and at the output.
// No dependencies.
module sawbc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

// ===== hdl/sawbc_front.sv =====
// Front end: takes accesses, classifies the opcode and trims the address.
// Depends on sawbc_pkg and sawbc_fifo.
module sawbc_front #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic [31:0]        address,
    input  logic [31:0]        word_data,
    input  logic [31:0]        write_mask,
    output logic               cmd_valid,
    output sawbc_pkg::cmd_t    cmd,
    input  logic               cmd_pop
);
    import sawbc_pkg::*;

    localparam logic [31:0] ADDR_MASK =
        (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

    cmd_t             in_cmd;
    logic             q_empty;
    logic [$bits(cmd_t)-1:0] q_rd;

    always_comb
    begin
        case (opcode)
            CMD_READ:   in_cmd.kind = CMD_READ;
            CMD_WRITE:  in_cmd.kind = CMD_WRITE;
            CMD_REFILL: in_cmd.kind = CMD_REFILL;
            default:    in_cmd.kind = CMD_ILLEGAL;
        endcase
        in_cmd.addr = address & ADDR_MASK;
        in_cmd.data = word_data;
        in_cmd.mask = write_mask;
    end

    sawbc_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = cmd_t'(q_rd);
endmodule

// ===== hdl/sawbc_back.sv =====
// Back end: tag lookup, hit handling, eviction, refill and result emission.
// Depends on sawbc_pkg and sawbc_ram.
module sawbc_back #(
    parameter int CACHE_BYTES_LOG2 = 14,
    parameter int WAYS_LOG2        = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sawbc_pkg::cmd_t    cmd,
    output logic               cmd_pop,
    input  logic               out_full,
    output logic               res_valid,
    output sawbc_pkg::res_t    res
);
    import sawbc_pkg::*;

    localparam int SET_BITS  = (CACHE_BYTES_LOG2 - LINE_BYTES_LOG2 > WAYS_LOG2) ?
                               (CACHE_BYTES_LOG2 - LINE_BYTES_LOG2 - WAYS_LOG2) : 0;
    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int NUM_WAYS  = 1 << WAYS_LOG2;
    localparam int LINE_W    = SET_BITS + WAYS_LOG2;
    localparam int NUM_LINES = 1 << LINE_W;
    localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W     = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
    localparam int TAG_W     = 32 - LINE_BYTES_LOG2 - SET_BITS;
    localparam int DA_W      = LINE_W + WORD_IDX_W;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
        return SET_W'((a >> LINE_BYTES_LOG2) & 32'(NUM_SETS - 1));
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
        return TAG_W'(a >> (LINE_BYTES_LOG2 + SET_BITS));
    endfunction

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return LINE_W'((32'(s) << WAYS_LOG2) | (32'(w) & 32'(NUM_WAYS - 1)));
    endfunction

    state_t state_reg, state_next;

    logic                  pending_reg;
    logic [WORD_IDX_W-1:0] count_reg;
    logic [15:0]           lfsr_reg;
    logic [NUM_LINES-1:0]  valid_reg;
    logic [NUM_LINES-1:0]  dirty_reg;
    logic [WORD_IDX_W-1:0] wb_idx_reg;

    logic                  pend_write_reg;
    logic [31:0]           pend_addr_reg;
    logic [31:0]           pend_wdata_reg;
    logic [31:0]           pend_mask_reg;
    logic [WAY_W-1:0]      pend_way_reg;

    logic                  cur_write_reg;
    logic [31:0]           cur_addr_reg;
    logic [31:0]           cur_wdata_reg;
    logic [31:0]           cur_mask_reg;
    logic [WAY_W-1:0]      cur_way_reg;
    logic [LINE_W-1:0]     cur_line_reg;
    logic                  cur_hit_reg;
    logic [BLOCK_W-1:0]    wb_block_reg;

    logic [SET_W-1:0]      cur_set;
    logic [TAG_W-1:0]      cur_tag;
    logic [WORD_IDX_W-1:0] cur_word;
    logic [LINE_W-1:0]     pend_line;

    logic [TAG_W-1:0]      tag_rd [NUM_WAYS];
    logic [NUM_WAYS-1:0]   tag_we;
    logic [SET_W-1:0]      tag_raddr;

    logic                  hit_any;
    logic [WAY_W-1:0]      hit_way;
    logic                  inv_any;
    logic [WAY_W-1:0]      inv_way;
    logic [WAY_W-1:0]      victim_way;
    logic [LINE_W-1:0]     hit_line;
    logic [LINE_W-1:0]     victim_line;
    logic                  victim_dirty;

    logic                  d_we;
    logic [DA_W-1:0]       d_waddr;
    logic [31:0]           d_wdata;
    logic [DA_W-1:0]       d_raddr;
    logic [31:0]           d_rdata;

    // Handshake events decided by the output logic.
    logic take_access;
    logic refill_word;
    logic refill_done;
    logic data_fire;
    logic wb_fire;
    logic req_fire;

    assign cur_set   = set_of(cur_addr_reg);
    assign cur_tag   = tag_of(cur_addr_reg);
    assign cur_word  = cur_addr_reg[LINE_BYTES_LOG2-1:2];
    assign pend_line = line_of(set_of(pend_addr_reg), pend_way_reg);

    // Lookup over the ways of the current set; lowest way wins.
    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[line_of(cur_set, WAY_W'(w))] && tag_rd[w] == cur_tag)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_reg[line_of(cur_set, WAY_W'(w))])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        victim_way   = inv_any ? inv_way : WAY_W'(32'(lfsr_reg) & 32'(NUM_WAYS - 1));
        hit_line     = line_of(cur_set, hit_way);
        victim_line  = line_of(cur_set, victim_way);
        victim_dirty = !inv_any && dirty_reg[victim_line];
    end

    assign tag_raddr = (state_reg == ST_IDLE) ? set_of(cmd.addr) : cur_set;

    for (genvar g = 0; g < NUM_WAYS; g++)
    begin : g_tag
        assign tag_we[g] = req_fire && (cur_way_reg == WAY_W'(g));

        sawbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SETS), .ADDR_W(SET_W)) u_tag_ram (
            .clk   (clk),
            .we    (tag_we[g]),
            .waddr (cur_set),
            .wdata (cur_tag),
            .raddr (tag_raddr),
            .rdata (tag_rd[g])
        );
    end

    sawbc_ram #(.WIDTH(32), .DEPTH(NUM_LINES * 16), .ADDR_W(DA_W)) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // Output and event logic.
    always_comb
    begin
        cmd_pop     = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        take_access = 1'b0;
        refill_word = 1'b0;
        refill_done = 1'b0;
        data_fire   = 1'b0;
        wb_fire     = 1'b0;
        req_fire    = 1'b0;
        d_we        = 1'b0;
        d_waddr     = {cur_line_reg, cur_word};
        d_wdata     = (d_rdata & ~cur_mask_reg) | (cur_wdata_reg & cur_mask_reg);
        d_raddr     = {cur_line_reg, cur_word};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (pending_reg && cmd.kind == CMD_REFILL)
                    begin
                        cmd_pop     = 1'b1;
                        refill_word = 1'b1;
                        refill_done = (count_reg == LAST_WORD);
                        d_we        = 1'b1;
                        d_waddr     = {pend_line, count_reg};
                        d_wdata     = cmd.data;
                    end
                    else if (!pending_reg &&
                             (cmd.kind == CMD_READ || cmd.kind == CMD_WRITE))
                    begin
                        cmd_pop     = 1'b1;
                        take_access = 1'b1;
                    end
                    else if (!out_full)
                    begin
                        cmd_pop     = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = RK_REJECT;
                        res.last    = 1'b1;
                    end
                end
            end
            ST_TAG:
            begin
                d_raddr = {hit_line, cur_word};
            end
            ST_DATA:
            begin
                if (!out_full)
                begin
                    data_fire = 1'b1;
                    res_valid = 1'b1;
                    res.kind  = cur_write_reg ? RK_WRITE : RK_READ;
                    res.data  = cur_write_reg ? 32'd0 : d_rdata;
                    res.hit   = cur_hit_reg;
                    res.last  = 1'b1;
                    d_we      = cur_write_reg;
                end
            end
            ST_WB_RD:
            begin
                d_raddr = {cur_line_reg, wb_idx_reg};
            end
            ST_WB_OUT:
            begin
                d_raddr = {cur_line_reg, wb_idx_reg};
                if (!out_full)
                begin
                    wb_fire   = 1'b1;
                    res_valid = 1'b1;
                    res.kind  = RK_WB;
                    res.data  = d_rdata;
                    res.block = wb_block_reg;
                    res.idx   = wb_idx_reg;
                end
            end
            ST_REQ:
            begin
                if (!out_full)
                begin
                    req_fire  = 1'b1;
                    res_valid = 1'b1;
                    res.kind  = RK_REFILL;
                    res.block = cur_addr_reg[31:LINE_BYTES_LOG2];
                    res.last  = 1'b1;
                end
            end
            ST_FIN:
            begin
                d_raddr = {cur_line_reg, cur_word};
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_access)
                begin
                    state_next = ST_TAG;
                end
                else if (refill_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_TAG:
            begin
                if (hit_any)
                begin
                    state_next = ST_DATA;
                end
                else if (victim_dirty)
                begin
                    state_next = ST_WB_RD;
                end
                else
                begin
                    state_next = ST_REQ;
                end
            end
            ST_DATA:
            begin
                if (data_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WB_RD:
            begin
                state_next = ST_WB_OUT;
            end
            ST_WB_OUT:
            begin
                if (wb_fire)
                begin
                    state_next = (wb_idx_reg == LAST_WORD) ? ST_REQ : ST_WB_RD;
                end
            end
            ST_REQ:
            begin
                if (req_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                state_next = ST_DATA;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            lfsr_reg    <= LFSR_SEED;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            wb_idx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (refill_word)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (refill_done)
            begin
                pending_reg          <= 1'b0;
                valid_reg[pend_line] <= 1'b1;
                dirty_reg[pend_line] <= 1'b0;
            end
            if (state_reg == ST_TAG && !hit_any)
            begin
                wb_idx_reg <= '0;
                if (!inv_any)
                begin
                    lfsr_reg <= {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                                 lfsr_reg[15:1]};
                end
            end
            if (wb_fire)
            begin
                wb_idx_reg <= wb_idx_reg + 1'b1;
            end
            if (data_fire && cur_write_reg)
            begin
                dirty_reg[cur_line_reg] <= 1'b1;
            end
            if (req_fire)
            begin
                pending_reg             <= 1'b1;
                count_reg               <= '0;
                valid_reg[cur_line_reg] <= 1'b0;
                dirty_reg[cur_line_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_access)
        begin
            cur_write_reg <= (cmd.kind == CMD_WRITE);
            cur_addr_reg  <= cmd.addr;
            cur_wdata_reg <= cmd.data;
            cur_mask_reg  <= cmd.mask;
        end
        if (refill_done)
        begin
            // finish the parked access on the freshly filled line
            cur_write_reg <= pend_write_reg;
            cur_addr_reg  <= pend_addr_reg;
            cur_wdata_reg <= pend_wdata_reg;
            cur_mask_reg  <= pend_mask_reg;
            cur_way_reg   <= pend_way_reg;
            cur_line_reg  <= pend_line;
            cur_hit_reg   <= 1'b0;
        end
        if (state_reg == ST_TAG)
        begin
            cur_hit_reg  <= hit_any;
            cur_way_reg  <= hit_any ? hit_way : victim_way;
            cur_line_reg <= hit_any ? hit_line : victim_line;
            wb_block_reg <= BLOCK_W'((32'(tag_rd[victim_way]) << SET_BITS) | 32'(cur_set));
        end
        if (req_fire)
        begin
            pend_write_reg <= cur_write_reg;
            pend_addr_reg  <= cur_addr_reg;
            pend_wdata_reg <= cur_wdata_reg;
            pend_mask_reg  <= cur_mask_reg;
            pend_way_reg   <= cur_way_reg;
        end
    end
endmodule

// ===== hdl/set_assoc_write_back_cache_top.sv =====
// Top level of the set-associative write-back cache.
// Depends on sawbc_pkg, sawbc_front, sawbc_back and sawbc_fifo.
//
//  channel   handshake        payload
//  access    push / full      opcode, address, word_data, write_mask
//  result    empty / pop      result_kind, out_data, block_number, word_index, hit, last
//
// A hit passes from push to result through queue, tag read, data read and emit.
// A miss adds a data RAM read and then an emit for each writeback word, and then the request;
// each refill word is written as it is taken, and the last one then finishes the access (line read, emit).
// The back end handles one word at a time; the two-entry queues on either side absorb stalls.
// Reset clears valid and dirty bits at once; tag and data RAMs need no clearing.
module set_assoc_write_back_cache_top #(
    parameter int CACHE_BYTES_LOG2 = 14,
    parameter int WAYS_LOG2        = 2,
    parameter int ADDRESS_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] address,
    input  logic [31:0] word_data,
    input  logic [31:0] write_mask,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [31:0] out_data,
    output logic [25:0] block_number,
    output logic [3:0]  word_index,
    output logic        hit,
    output logic        last
);
    import sawbc_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic out_full;
    logic res_valid;
    res_t res;
    logic [$bits(res_t)-1:0] out_rd;
    res_t out_res;

    sawbc_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .address    (address),
        .word_data  (word_data),
        .write_mask (write_mask),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    sawbc_back #(.CACHE_BYTES_LOG2(CACHE_BYTES_LOG2), .WAYS_LOG2(WAYS_LOG2)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .res_valid (res_valid),
        .res       (res)
    );

    sawbc_fifo #(.WIDTH($bits(res_t))) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd),
        .empty   (empty)
    );

    assign out_res      = res_t'(out_rd);
    assign result_kind  = out_res.kind;
    assign out_data     = out_res.data;
    assign block_number = out_res.block;
    assign word_index   = out_res.idx;
    assign hit          = out_res.hit;
    assign last         = out_res.last;
endmodule

// ===== hdl/sawbc_checker.sv =====
// Port-level checks for the cache top level, attached by bind.
// Depends on sawbc_pkg and set_assoc_write_back_cache_top.
module sawbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  result_kind,
    input logic [31:0] out_data,
    input logic [3:0]  word_index,
    input logic        hit,
    input logic        last
);
    import sawbc_pkg::*;

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result_kind <= RK_REJECT)
        else $error("result kind out of range");

    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == RK_WB) |-> !last)
        else $error("writeback word marked last");

    a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result_kind == RK_WB || result_kind == RK_REFILL ||
                    result_kind == RK_REJECT)) |-> !hit)
        else $error("hit flag on a non-access result");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != RK_WB) |-> word_index == 4'd0)
        else $error("word index set outside writeback");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(out_data)))
        else $error("stalled result changed");
endmodule

bind set_assoc_write_back_cache_top sawbc_checker u_sawbc_checker (.*);

// ===== test/tb_set_assoc_write_back_cache_top.sv =====
// Testbench for set_assoc_write_back_cache_top: directed table, then random cache traffic.
// Needs sawbc_pkg and the cache RTL; every result is checked against a built-in cache predictor.
module tb_set_assoc_write_back_cache_top;
    import sawbc_pkg::*;

    localparam int LINES     = 256;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] word_data;
    logic [31:0] write_mask;
    logic        empty;
    logic        pop;
    logic [2:0]  result_kind;
    logic [31:0] out_data;
    logic [25:0] block_number;
    logic [3:0]  word_index;
    logic        hit;
    logic        last;

    set_assoc_write_back_cache_top u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .opcode(opcode), .address(address), .word_data(word_data),
        .write_mask(write_mask), .empty(empty), .pop(pop),
        .result_kind(result_kind), .out_data(out_data),
        .block_number(block_number), .word_index(word_index),
        .hit(hit), .last(last)
    );

    // cache shadow state
    logic [19:0] tag_mem [LINES];
    bit          line_vld [LINES];
    bit          line_dirty [LINES];
    logic [31:0] data_mem [LINES*16];
    logic [15:0] victim_lfsr;
    bit          fill_busy;
    bit          fill_is_wr;
    logic [31:0] fill_addr;
    logic [31:0] fill_wdata;
    logic [31:0] fill_mask;
    logic [1:0]  fill_way;
    logic [3:0]  fill_cnt;

    res_t        pending_results [$];
    int          errors;
    int          burst_left;
    logic [19:0] tag_pool [6];

    typedef struct {
        cmd_kind_t   op;
        logic [31:0] a;
        logic [31:0] d;
        logic [31:0] m;
        int          reps;
        bit          typed;
        res_kind_t   ek;
    } row_t;

    row_t dir_rows [11];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("set_assoc_write_back_cache_top verification failed");
        $finish;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void add_result(res_kind_t k, logic [31:0] d, logic [25:0] b,
                                       logic [3:0] i, logic h, logic l);
        res_t r;
        r.kind  = k;
        r.data  = d;
        r.block = b;
        r.idx   = i;
        r.hit   = h;
        r.last  = l;
        pending_results.push_back(r);
    endfunction

    function automatic void complete_access(int line, bit wr, logic [3:0] w,
                                            logic [31:0] d, logic [31:0] m, logic h);
        int at;
        at = line * 16 + w;
        if (wr)
        begin
            data_mem[at] = (data_mem[at] & ~m) | (d & m);
            line_dirty[line] = 1'b1;
            add_result(RK_WRITE, '0, '0, '0, h, 1'b1);
        end
        else
            add_result(RK_READ, data_mem[at], '0, '0, h, 1'b1);
    endfunction

    // Work out the results of one accepted word and advance the shadow state.
    function automatic void predict_cache(logic [1:0] op, logic [31:0] a,
                                          logic [31:0] d, logic [31:0] m);
        logic [5:0]  set;
        logic [19:0] tg;
        int          base;
        int          way;
        int          line;
        bit          found;
        logic        fb;
        if (fill_busy)
        begin
            if (op != CMD_REFILL)
            begin
                add_result(RK_REJECT, '0, '0, '0, 1'b0, 1'b1);
                return;
            end
            line = fill_addr[11:6] * 4 + fill_way;
            data_mem[line * 16 + fill_cnt] = d;
            if (fill_cnt != LAST_WORD)
            begin
                fill_cnt++;
                return;
            end
            fill_cnt = '0;
            fill_busy = 1'b0;
            line_vld[line] = 1'b1;
            line_dirty[line] = 1'b0;
            complete_access(line, fill_is_wr, fill_addr[5:2], fill_wdata, fill_mask, 1'b0);
            return;
        end
        if (op == CMD_REFILL || op == CMD_ILLEGAL)
        begin
            add_result(RK_REJECT, '0, '0, '0, 1'b0, 1'b1);
            return;
        end
        set = a[11:6];
        tg = a[31:12];
        base = set * 4;
        for (int w = 0; w < 4; w++)
            if (line_vld[base + w] && tag_mem[base + w] == tg)
            begin
                complete_access(base + w, op == CMD_WRITE, a[5:2], d, m, 1'b1);
                return;
            end
        found = 1'b0;
        way = 0;
        for (int w = 0; w < 4; w++)
            if (!found && !line_vld[base + w])
            begin
                way = w;
                found = 1'b1;
            end
        if (!found)
        begin
            fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
            way = victim_lfsr[1:0];
            victim_lfsr = {fb, victim_lfsr[15:1]};
            if (line_dirty[base + way])
                for (int w = 0; w < 16; w++)
                    add_result(RK_WB, data_mem[(base + way) * 16 + w],
                               {tag_mem[base + way], set}, w[3:0], 1'b0, 1'b0);
        end
        line_vld[base + way] = 1'b0;
        line_dirty[base + way] = 1'b0;
        tag_mem[base + way] = tg;
        fill_busy = 1'b1;
        fill_is_wr = (op == CMD_WRITE);
        fill_addr = a;
        fill_wdata = d;
        fill_mask = m;
        fill_way = way[1:0];
        fill_cnt = '0;
        add_result(RK_REFILL, '0, a[31:6], '0, 1'b0, 1'b1);
    endfunction

    // Offer one word in bursts; hold push across back-to-back words.
    task automatic send_word(logic [1:0] op, logic [31:0] a, logic [31:0] d, logic [31:0] m);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push       <= 1'b1;
        opcode     <= op;
        address    <= a;
        word_data  <= d;
        write_mask <= m;
        do @(posedge clk); while (full);
        predict_cache(op, a, d, m);
    endtask

    int          pop_run;
    int          pop_mode;
    res_t        want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                    report("unexpected word", result_kind, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_kind !== want.kind)  report("result_kind", result_kind, want.kind);
                    if (out_data !== want.data)     report("out_data", out_data, want.data);
                    if (block_number !== want.block)
                        report("block_number", block_number, want.block);
                    if (word_index !== want.idx)    report("word_index", word_index, want.idx);
                    if (hit !== want.hit)           report("hit", hit, want.hit);
                    if (last !== want.last)         report("last", last, want.last);
                end
            end
            // receiver stall pattern: free-run, random, or mostly stalled
            if (pop_run == 0)
            begin
                pop_run  <= $urandom_range(1, 20);
                pop_mode <= $urandom % 3;
            end
            else
                pop_run <= pop_run - 1;
            pop <= (pop_mode == 0) ? 1'b1 : (pop_mode == 1) ? 1'($urandom % 2)
                                                            : 1'($urandom % 4 == 0);
        end
    end

    initial begin
        logic [1:0]  op;
        logic [31:0] a;
        int          sent;
        int          r;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        opcode = '0;
        address = '0;
        word_data = '0;
        write_mask = '0;
        errors = 0;
        burst_left = 0;
        pop_run = 0;
        pop_mode = 0;
        for (int i = 0; i < LINES; i++)
        begin
            line_vld[i] = 1'b0;
            line_dirty[i] = 1'b0;
        end
        victim_lfsr = LFSR_SEED;
        fill_busy = 1'b0;
        fill_is_wr = 1'b0;
        fill_addr = '0;
        fill_wdata = '0;
        fill_mask = '0;
        fill_way = '0;
        fill_cnt = '0;
        for (int i = 0; i < 6; i++)
            tag_pool[i] = 20'($urandom);

        dir_rows = '{
            '{CMD_REFILL,  32'h0,        32'h0,        32'h0,        1,  1'b1, RK_REJECT},
            '{CMD_ILLEGAL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,  1'b1, RK_REJECT},
            '{CMD_READ,    32'h0,        32'h0,        32'h0,        1,  1'b0, RK_READ},
            '{CMD_WRITE,   32'h4,        32'h1,        32'h1,        1,  1'b1, RK_REJECT},
            '{CMD_REFILL,  32'h0,        32'ha5a5a500, 32'h0,        16, 1'b0, RK_READ},
            '{CMD_WRITE,   32'h3c,       32'hffffffff, 32'hffff0000, 1,  1'b0, RK_WRITE},
            '{CMD_READ,    32'h3c,       32'h0,        32'h0,        1,  1'b0, RK_READ},
            '{CMD_READ,    32'hfffffffc, 32'h0,        32'h0,        1,  1'b0, RK_READ},
            '{CMD_REFILL,  32'h0,        32'h5a5a5a00, 32'h0,        16, 1'b0, RK_READ},
            '{CMD_WRITE,   32'hfffffffc, 32'h0,        32'hffffffff, 1,  1'b0, RK_WRITE},
            '{CMD_READ,    32'hfffffffc, 32'h0,        32'h0,        1,  1'b0, RK_READ}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
            begin
                send_word(dir_rows[i].op, dir_rows[i].a, dir_rows[i].d + k, dir_rows[i].m);
                if (dir_rows[i].typed)
                begin
                    // replace the predicted word with the one read off the spec
                    void'(pending_results.pop_back());
                    add_result(dir_rows[i].ek, '0, '0, '0, 1'b0, 1'b1);
                end
            end

        sent = 0;
        while (sent < 290)
        begin
            r = $urandom % 100;
            if (fill_busy)
            begin
                if (r < 92)
                    op = CMD_REFILL;
                else
                    op = 2'($urandom);
            end
            else if (r < 4)
                op = CMD_ILLEGAL;
            else if (r < 8)
                op = CMD_REFILL;
            else
                op = ($urandom % 2) ? CMD_WRITE : CMD_READ;
            // mostly a few sets and tags so that hits, fills and evictions all occur
            if ($urandom % 100 < 15)
                a = $urandom;
            else
                a = {tag_pool[$urandom % 6], 6'($urandom_range(0, 3)), 6'($urandom)};
            send_word(op, a, $urandom, ($urandom % 4 == 0) ? 32'hffffffff : $urandom);
            sent++;
        end
        push <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("set_assoc_write_back_cache_top verification clean");
        else
            $display("set_assoc_write_back_cache_top verification failed");
        $finish;
    end

endmodule
